// ----- rtl/kbrf_pkg.sv -----
// Shared types and constants for the key ban and remap filter.
// No dependencies; used by kbrf_table and key_ban_and_remap_filter_top.
package kbrf_pkg;

	localparam int KEY_W = 8;
	localparam int OP_W = 3;
	localparam int STATUS_W = 2;

	localparam int BAN_DEPTH_DEF = 16;
	localparam int REMAP_DEPTH_DEF = 16;

	// a banned key that is not also remapped reads back as this code on a check
	localparam logic [KEY_W-1:0] BAN_OUT_KEY = 8'h00;

	typedef enum logic [OP_W-1:0] {
		OP_BAN     = 3'd0,
		OP_UNBAN   = 3'd1,
		OP_REMAP   = 3'd2,
		OP_UNREMAP = 3'd3,
		OP_CHECK   = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_REFUSED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// update request into a table, only raised when the item executes
	typedef struct packed {
		logic insert;
		logic remove;
	} tbl_cmd_t;

	// lookup result out of a table
	typedef struct packed {
		logic hit;
		logic full;
	} tbl_look_t;

endpackage

// ----- rtl/kbrf_table.sv -----
// Associative key table: parallel key compare, lowest-free-slot insert, remove on hit.
// Depends on kbrf_pkg.
module kbrf_table
	import kbrf_pkg::*;
#(
	parameter int DEPTH = BAN_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tbl_cmd_t         cmd,
	input  logic [KEY_W-1:0] key,
	input  logic [KEY_W-1:0] wdata,
	output tbl_look_t        look,
	output logic [KEY_W-1:0] rdata
);

	logic [DEPTH-1:0] valid_q;
	logic [KEY_W-1:0] keys_q [DEPTH];
	logic [KEY_W-1:0] data_q [DEPTH];

	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] free_vec;
	logic [DEPTH-1:0] free_oh;
	logic             do_insert;
	logic             do_remove;

	// parallel compare; keys are unique so at most one entry matches
	always_comb begin
		rdata = '0;
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == key);
			rdata = rdata | (data_q[i] & {KEY_W{match[i]}});
		end
	end

	// lowest free slot as a one-hot mask
	assign free_vec = ~valid_q;
	assign free_oh  = free_vec & (~free_vec + DEPTH'(1));

	assign look.hit  = |match;
	assign look.full = &valid_q;

	assign do_insert = cmd.insert && !look.hit && !look.full;
	assign do_remove = cmd.remove && look.hit;

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (do_insert) begin
			valid_q <= valid_q | free_oh;
		end else if (do_remove) begin
			valid_q <= valid_q & ~match;
		end
	end

	// entry contents, gated by the valid bits
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (do_insert && free_oh[i]) begin
				keys_q[i] <= key;
				data_q[i] <= wdata;
			end
		end
	end

endmodule

// ----- rtl/key_ban_and_remap_filter_top.sv -----
// Key ban and remap filter, top level.
// Path to result: input register, then result register.
// One item per cycle when out_stall is low; table compare is between the registers.
// Reset: arst_n clears both tables' valid bits and the pipeline valids at once.
// Depends on kbrf_pkg and kbrf_table.
module key_ban_and_remap_filter_top
	import kbrf_pkg::*;
#(
	parameter int BAN_DEPTH = BAN_DEPTH_DEF,
	parameter int REMAP_DEPTH = REMAP_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [KEY_W-1:0]    key,
	input  logic [KEY_W-1:0]    redirect_key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [KEY_W-1:0]    out_key
);

	logic                valid_s1;
	logic [OP_W-1:0]     opcode_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [KEY_W-1:0]    redirect_s1;

	logic                valid_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [KEY_W-1:0]    out_key_s2;

	logic                s2_open;
	logic                fire_s1;
	logic                in_xfer;

	tbl_cmd_t            ban_cmd;
	tbl_cmd_t            remap_cmd;
	tbl_look_t           ban_look;
	tbl_look_t           remap_look;
	logic [KEY_W-1:0]    ban_rdata;
	logic [KEY_W-1:0]    remap_rdata;

	status_t             status_nx;
	logic [KEY_W-1:0]    out_key_nx;

	// flow control
	assign s2_open  = !valid_s2 || !out_stall;
	assign fire_s1  = valid_s1 && s2_open;
	assign in_stall = valid_s1 && !s2_open;
	assign in_xfer  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1   <= opcode;
			key_s1      <= key;
			redirect_s1 <= redirect_key;
		end
	end

	// table updates only when the item moves on
	always_comb begin
		ban_cmd.insert   = fire_s1 && (opcode_s1 == OP_BAN);
		ban_cmd.remove   = fire_s1 && (opcode_s1 == OP_UNBAN);
		remap_cmd.insert = fire_s1 && (opcode_s1 == OP_REMAP);
		remap_cmd.remove = fire_s1 && (opcode_s1 == OP_UNREMAP);
	end

	// banned keys map to the fixed ban code
	kbrf_table #(
		.DEPTH(BAN_DEPTH)
	) u_ban (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ban_cmd),
		.key   (key_s1),
		.wdata (BAN_OUT_KEY),
		.look  (ban_look),
		.rdata (ban_rdata)
	);

	kbrf_table #(
		.DEPTH(REMAP_DEPTH)
	) u_remap (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (remap_cmd),
		.key   (key_s1),
		.wdata (redirect_s1),
		.look  (remap_look),
		.rdata (remap_rdata)
	);

	// result of the item in the input register
	always_comb begin
		status_nx  = ST_REFUSED;
		out_key_nx = '0;
		unique case (opcode_t'(opcode_s1))
			OP_BAN, OP_REMAP: begin
				if ((opcode_s1 == OP_BAN) ? ban_look.hit : remap_look.hit) begin
					status_nx = ST_REFUSED;
				end else if ((opcode_s1 == OP_BAN) ? ban_look.full : remap_look.full) begin
					status_nx = ST_FULL;
				end else begin
					status_nx = ST_DONE;
				end
			end
			OP_UNBAN: begin
				status_nx = ban_look.hit ? ST_DONE : ST_REFUSED;
			end
			OP_UNREMAP: begin
				status_nx = remap_look.hit ? ST_DONE : ST_REFUSED;
			end
			OP_CHECK: begin
				status_nx = ST_DONE;
				priority if (remap_look.hit) begin
					out_key_nx = remap_rdata;
				end else if (ban_look.hit) begin
					out_key_nx = ban_rdata;
				end else begin
					out_key_nx = key_s1;
				end
			end
			default: begin
				status_nx  = ST_REFUSED;
				out_key_nx = '0;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_open) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2  <= status_nx;
			out_key_s2 <= out_key_nx;
		end
	end

	assign out_valid = valid_s2;
	assign status    = status_s2;
	assign out_key   = out_key_s2;

	// checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with no item held");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_open |=> valid_s1 && $stable(key_s1) && $stable(opcode_s1))
		else $error("held item lost from input register");

	a_check_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (opcode_s1 == OP_CHECK) |=> valid_s2 && (status_s2 == ST_DONE))
		else $error("check transfer did not complete as done");

	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && (opcode_s1 > OP_CHECK)
		|=> (status_s2 == ST_REFUSED) && (out_key_s2 == '0))
		else $error("unused opcode not refused");

	a_table_write_fires: assert property (@(posedge clk) disable iff (!arst_n)
		ban_cmd.insert || ban_cmd.remove || remap_cmd.insert || remap_cmd.remove
		|-> fire_s1)
		else $error("table update without a transfer");

endmodule
